### design/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg: text glyph renderer shared types
// Item and cell word formats, queue entry, config codes and the 5x7 font.
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

    typedef struct packed {
        logic              action;
        logic [7:0]        char_code;
        logic signed [15:0] new_cursor_x;
        logic signed [15:0] new_cursor_y;
    } char_item_t;

    typedef struct packed {
        logic [7:0]  rect_x;
        logic [6:0]  rect_y;
        logic [7:0]  rect_w;
        logic [7:0]  rect_h;
        logic [15:0] cell_color;
        logic        visible;
        logic        last_cell;
    } cell_item_t;

    // Five glyph columns, element 0 is the leftmost; bit n is row n from the top.
    typedef logic [0:4][7:0] glyph_t;

    typedef struct packed {
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        glyph_t      glyph;
    } cell_job_t;

    typedef struct packed {
        logic [7:0]  text_scale;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
    } render_cfg_t;

    localparam logic [1:0] CFG_TEXT_SCALE = 2'd0;
    localparam logic [1:0] CFG_FG_COLOR   = 2'd1;
    localparam logic [1:0] CFG_BG_COLOR   = 2'd2;

    localparam logic ACTION_DRAW       = 1'b0;
    localparam logic ACTION_SET_CURSOR = 1'b1;

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_RETURN  = 8'd13;
    localparam logic [7:0] FIRST_CODE   = 8'd32;
    localparam logic [7:0] LAST_CODE    = 8'd126;
    localparam logic [7:0] SUBST_CODE   = 8'd63;

    localparam logic [2:0] SPACE_COL = 3'd5;
    localparam logic [2:0] LAST_ROW  = 3'd6;

    function automatic glyph_t font_glyph(input logic [6:0] idx);
        glyph_t g;
        unique case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00005F0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147F147F14;
            7'd4:  g = 40'h242A7F2A12;
            7'd5:  g = 40'h2313086462;
            7'd6:  g = 40'h3649552250;
            7'd7:  g = 40'h0005030000;
            7'd8:  g = 40'h001C224100;
            7'd9:  g = 40'h0041221C00;
            7'd10: g = 40'h082A1C2A08;
            7'd11: g = 40'h08083E0808;
            7'd12: g = 40'h0050300000;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0060600000;
            7'd15: g = 40'h2010080402;
            7'd16: g = 40'h3E5149453E;
            7'd17: g = 40'h00427F4000;
            7'd18: g = 40'h4261514946;
            7'd19: g = 40'h2141454B31;
            7'd20: g = 40'h1814127F10;
            7'd21: g = 40'h2745454539;
            7'd22: g = 40'h3C4A494930;
            7'd23: g = 40'h0171090503;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h064949291E;
            7'd26: g = 40'h0036360000;
            7'd27: g = 40'h0056360000;
            7'd28: g = 40'h0008142241;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h4122140800;
            7'd31: g = 40'h0201510906;
            7'd32: g = 40'h324979413E;
            7'd33: g = 40'h7E1111117E;
            7'd34: g = 40'h7F49494936;
            7'd35: g = 40'h3E41414122;
            7'd36: g = 40'h7F4141221C;
            7'd37: g = 40'h7F49494941;
            7'd38: g = 40'h7F09090101;
            7'd39: g = 40'h3E41415132;
            7'd40: g = 40'h7F0808087F;
            7'd41: g = 40'h00417F4100;
            7'd42: g = 40'h2040413F01;
            7'd43: g = 40'h7F08142241;
            7'd44: g = 40'h7F40404040;
            7'd45: g = 40'h7F0204027F;
            7'd46: g = 40'h7F0408107F;
            7'd47: g = 40'h3E4141413E;
            7'd48: g = 40'h7F09090906;
            7'd49: g = 40'h3E4151215E;
            7'd50: g = 40'h7F09192946;
            7'd51: g = 40'h4649494931;
            7'd52: g = 40'h01017F0101;
            7'd53: g = 40'h3F4040403F;
            7'd54: g = 40'h1F2040201F;
            7'd55: g = 40'h7F2018207F;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0304780403;
            7'd58: g = 40'h6151494543;
            7'd59: g = 40'h00007F4141;
            7'd60: g = 40'h0204081020;
            7'd61: g = 40'h41417F0000;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040;
            7'd64: g = 40'h0001020400;
            7'd65: g = 40'h2054545478;
            7'd66: g = 40'h7F48444438;
            7'd67: g = 40'h3844444420;
            7'd68: g = 40'h384444487F;
            7'd69: g = 40'h3854545418;
            7'd70: g = 40'h087E090102;
            7'd71: g = 40'h081454543C;
            7'd72: g = 40'h7F08040478;
            7'd73: g = 40'h00447D4000;
            7'd74: g = 40'h2040443D00;
            7'd75: g = 40'h007F102844;
            7'd76: g = 40'h00417F4000;
            7'd77: g = 40'h7C04180478;
            7'd78: g = 40'h7C08040478;
            7'd79: g = 40'h3844444438;
            7'd80: g = 40'h7C14141408;
            7'd81: g = 40'h081414187C;
            7'd82: g = 40'h7C08040408;
            7'd83: g = 40'h4854545420;
            7'd84: g = 40'h043F444020;
            7'd85: g = 40'h3C4040207C;
            7'd86: g = 40'h1C2040201C;
            7'd87: g = 40'h3C4030403C;
            7'd88: g = 40'h4428102844;
            7'd89: g = 40'h0C5050503C;
            7'd90: g = 40'h4464544C44;
            7'd91: g = 40'h0008364100;
            7'd92: g = 40'h00007F0000;
            7'd93: g = 40'h0041360800;
            7'd94: g = 40'h08082A1C08;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

### design/tgr_front.sv
// ----------------------------------------------------------------------------
// tgr_front: item intake and cursor
// Classifies items, keeps the cursor and queues one job per drawn glyph.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               char_valid,
    output logic                    char_ready,
    input  wire tgr_pkg::char_item_t char_item,
    input  wire logic [7:0]         text_scale,
    output logic                    job_valid,
    input  wire logic               job_ready,
    output tgr_pkg::cell_job_t      job
);
    import tgr_pkg::*;

    logic [15:0] cursor_col_reg, cursor_col_next;
    logic [15:0] cursor_row_reg, cursor_row_next;
    logic        accept;
    logic        is_set, is_newline, is_return, is_draw;
    logic        printable;
    logic [7:0]  glyph_code;
    logic [6:0]  glyph_idx;
    logic [15:0] line_step;
    logic [15:0] advance_step;

    assign char_ready = job_ready;
    assign accept     = char_valid && char_ready;

    assign is_set     = (char_item.action == ACTION_SET_CURSOR);
    assign is_newline = !is_set && (char_item.char_code == CODE_NEWLINE);
    assign is_return  = !is_set && (char_item.char_code == CODE_RETURN);
    assign is_draw    = !is_set && !is_newline && !is_return;

    assign printable  = (char_item.char_code >= FIRST_CODE) &&
                        (char_item.char_code <= LAST_CODE);
    assign glyph_code = printable ? char_item.char_code : SUBST_CODE;
    assign glyph_idx  = glyph_code[6:0] - FIRST_CODE[6:0];

    assign line_step    = {5'd0, text_scale, 3'd0};
    assign advance_step = {6'd0, text_scale, 2'd0} + {7'd0, text_scale, 1'd0};

    assign job_valid    = char_valid && is_draw;
    assign job.origin_x = cursor_col_reg;
    assign job.origin_y = cursor_row_reg;
    assign job.glyph    = font_glyph(glyph_idx);

    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        if (accept)
        begin
            if (is_set)
            begin
                cursor_col_next = char_item.new_cursor_x;
                cursor_row_next = char_item.new_cursor_y;
            end
            else if (is_newline)
            begin
                cursor_col_next = 16'd0;
                cursor_row_next = cursor_row_reg + line_step;
            end
            else if (is_return)
            begin
                cursor_col_next = 16'd0;
            end
            else
            begin
                cursor_col_next = cursor_col_reg + advance_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= 16'd0;
            cursor_row_reg <= 16'd0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

endmodule

`default_nettype wire

### design/tgr_queue.sv
// ----------------------------------------------------------------------------
// tgr_queue: glyph job queue
// Two-entry FIFO between intake and cell sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire tgr_pkg::cell_job_t push_job,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output tgr_pkg::cell_job_t      head
);
    import tgr_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cell_job_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/tgr_back.sv
// ----------------------------------------------------------------------------
// tgr_back: cell sequencer
// Walks the 6x7 cells of a glyph job, clips each cell and registers it out.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_back #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 128
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 job_valid,
    output logic                      job_pop,
    input  wire tgr_pkg::cell_job_t   job,
    input  wire tgr_pkg::render_cfg_t cfg,
    output logic                      cell_valid,
    input  wire logic                 cell_ready,
    output tgr_pkg::cell_item_t       cell_item
);
    import tgr_pkg::*;

    localparam logic signed [17:0] X_LIMIT = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] Y_LIMIT = 18'(SCREEN_HEIGHT);

    typedef struct packed {
        logic       hit;
        logic [9:0] start;
        logic [7:0] size;
    } span_t;

    function automatic span_t clip_span(input logic [15:0] origin, input logic [7:0] len,
                                        input logic signed [17:0] limit);
        span_t             sp;
        logic signed [17:0] lo, hi, lo_c, hi_c, diff;
        lo      = $signed({{2{origin[15]}}, origin});
        hi      = lo + $signed({10'd0, len});
        sp.hit  = (lo < limit) && (hi > 18'sd0);
        lo_c    = (lo < 18'sd0) ? 18'sd0 : lo;
        hi_c    = (hi > limit) ? limit : hi;
        diff    = hi_c - lo_c;
        sp.start = lo_c[9:0];
        sp.size  = diff[7:0];
        return sp;
    endfunction

    logic [2:0]  col_reg, col_next;
    logic [2:0]  row_reg, row_next;
    logic [15:0] xoff_reg, xoff_next;
    logic [15:0] yoff_reg, yoff_next;
    logic        cell_valid_reg, cell_valid_next;
    cell_item_t  cell_item_reg, cell_item_next;
    logic        advance;
    logic        last_row, last_col;
    logic [15:0] cell_x, cell_y;
    span_t       span_x, span_y;
    logic        vis;
    logic        ink;

    assign advance  = job_valid && (!cell_valid_reg || cell_ready);
    assign last_row = (row_reg == LAST_ROW);
    assign last_col = (col_reg == SPACE_COL);
    assign job_pop  = advance && last_row && last_col;

    assign cell_x = job.origin_x + xoff_reg;
    assign cell_y = job.origin_y + yoff_reg;
    assign span_x = clip_span(cell_x, cfg.text_scale, X_LIMIT);
    assign span_y = clip_span(cell_y, cfg.text_scale, Y_LIMIT);
    assign vis    = span_x.hit && span_y.hit;
    assign ink    = !last_col && job.glyph[col_reg][row_reg];

    always_comb
    begin
        cell_item_next.rect_x     = vis ? span_x.start[7:0] : 8'd0;
        cell_item_next.rect_y     = vis ? span_y.start[6:0] : 7'd0;
        cell_item_next.rect_w     = vis ? span_x.size : 8'd0;
        cell_item_next.rect_h     = vis ? span_y.size : 8'd0;
        cell_item_next.cell_color = ink ? cfg.fg_color : cfg.bg_color;
        cell_item_next.visible    = vis;
        cell_item_next.last_cell  = last_row && last_col;
    end

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        xoff_next       = xoff_reg;
        yoff_next       = yoff_reg;
        cell_valid_next = cell_valid_reg && !cell_ready;
        if (advance)
        begin
            cell_valid_next = 1'b1;
            if (last_row)
            begin
                row_next  = 3'd0;
                yoff_next = 16'd0;
                if (last_col)
                begin
                    col_next  = 3'd0;
                    xoff_next = 16'd0;
                end
                else
                begin
                    col_next  = col_reg + 3'd1;
                    xoff_next = xoff_reg + {8'd0, cfg.text_scale};
                end
            end
            else
            begin
                row_next  = row_reg + 3'd1;
                yoff_next = yoff_reg + {8'd0, cfg.text_scale};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cell_item_reg <= cell_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= 3'd0;
            row_reg        <= 3'd0;
            xoff_reg       <= 16'd0;
            yoff_reg       <= 16'd0;
            cell_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            xoff_reg       <= xoff_next;
            yoff_reg       <= yoff_next;
            cell_valid_reg <= cell_valid_next;
        end
    end

    assign cell_valid = cell_valid_reg;
    assign cell_item  = cell_item_reg;

endmodule

`default_nettype wire

### design/text_glyph_cell_renderer_top.sv
// ----------------------------------------------------------------------------
// text_glyph_cell_renderer_top: 5x7 text renderer producing fill cells
// A drawn character is queued as a job; the sequencer registers each cell out.
// 42 cells per glyph, one per cycle while a job waits and cell_ready is high.
// Reset: cursor at 0,0, scale 1, white on black, job queue empty; ready right after.
// ----------------------------------------------------------------------------
`default_nettype none

module text_glyph_cell_renderer_top #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 128
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                char_valid,
    output logic                     char_ready,
    input  wire tgr_pkg::char_item_t char_item,
    output logic                     cell_valid,
    input  wire logic                cell_ready,
    output tgr_pkg::cell_item_t      cell_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import tgr_pkg::*;

    render_cfg_t cfg_reg, cfg_next;
    logic        job_in_valid, job_in_ready;
    cell_job_t   job_in;
    logic        job_out_valid, job_out_pop;
    cell_job_t   job_out;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TEXT_SCALE: cfg_next.text_scale = (cfg_data[7:0] == 8'd0) ? 8'd1
                                                                              : cfg_data[7:0];
                CFG_FG_COLOR:   cfg_next.fg_color = cfg_data;
                CFG_BG_COLOR:   cfg_next.bg_color = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_scale <= 8'd1;
            cfg_reg.fg_color   <= 16'hFFFF;
            cfg_reg.bg_color   <= 16'h0000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tgr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .text_scale (cfg_reg.text_scale),
        .job_valid  (job_in_valid),
        .job_ready  (job_in_ready),
        .job        (job_in)
    );

    tgr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_in_valid),
        .push_ready (job_in_ready),
        .push_job   (job_in),
        .pop_valid  (job_out_valid),
        .pop_ready  (job_out_pop),
        .head       (job_out)
    );

    tgr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_out_valid),
        .job_pop    (job_out_pop),
        .job        (job_out),
        .cfg        (cfg_reg),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_item  (cell_item)
    );

endmodule

`default_nettype wire

### design/tgr_checker.sv
// ----------------------------------------------------------------------------
// tgr_checker: port-level checks for the text renderer
// Cell word hold, clipping consistency and end-of-glyph spacing.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                cell_valid,
    input wire logic                cell_ready,
    input wire tgr_pkg::cell_item_t cell_item
);
    import tgr_pkg::*;

    a_cell_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && !cell_ready |=> cell_valid && $stable(cell_item))
        else $error("cell word changed while stalled");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && !cell_item.visible |->
            cell_item.rect_x == 8'd0 && cell_item.rect_y == 7'd0 &&
            cell_item.rect_w == 8'd0 && cell_item.rect_h == 8'd0)
        else $error("hidden cell carries geometry");

    a_shown_size: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && cell_item.visible |-> cell_item.rect_w != 8'd0 && cell_item.rect_h != 8'd0)
        else $error("visible cell with empty size");

    a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && cell_ready && cell_item.last_cell |=> !cell_valid || !cell_item.last_cell)
        else $error("two glyph ends in a row");

endmodule

bind text_glyph_cell_renderer_top tgr_checker u_tgr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .cell_item  (cell_item)
);

`default_nettype wire
